>>> sv/fsq_pkg.sv
// Shared types and constants for the searchable FIFO queue.
// No dependencies; every other file of the block imports this package.
package fsq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 5;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_FIND   = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type                opcode;
      logic signed [DATA_W-1:0]  item_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result_value;
      status_type                status;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   // One write and one read access to the entry memory per cycle.
   typedef struct packed {
      logic                      we;
      logic [ADDR_W-1:0]         waddr;
      logic signed [DATA_W-1:0]  wdata;
      logic [ADDR_W-1:0]         raddr;
   } ram_req_type;

   typedef struct packed {
      logic                      valid;
      rsp_type                   rsp;
   } done_type;

   // Step a circular-buffer address by one place.
   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == ADDR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + ADDR_W'(1);
      end
      return r;
   endfunction

endpackage

>>> sv/fsq_ram.sv
// Entry memory of the queue: one write port, one read port, registered read.
// Depends on fsq_pkg for depth, widths and the access struct.
module fsq_ram
   import fsq_pkg::*;
(
   input  logic                     clock,
   input  ram_req_type              ram_req,
   output logic signed [DATA_W-1:0] rdata
);

   logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[ram_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/fsq_ctrl.sv
// Operation sequencer: head/count bookkeeping, linear search and compaction.
// Depends on fsq_pkg; drives the fsq_ram access port.
module fsq_ctrl
   import fsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   input  logic                     out_free,
   input  logic signed [DATA_W-1:0] rdata,
   output ram_req_type              ram_req,
   output done_type                 done
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_POPRD = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        hd_ff, hd_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0]        pa_ff, pa_in;
   logic [ADDR_W-1:0]        wa_ff, wa_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   opcode_type               op_ff, op_in;
   rsp_type                  res_ff, res_in;

   logic [ADDR_W:0]          tsum;
   logic [ADDR_W-1:0]        tail;
   logic [CNT_W-1:0]         cnt_dec;
   logic                     last;
   logic [ADDR_W-1:0]        pa_next;

   // Physical tail = (head + count) wrapped once.
   assign tsum    = {1'b0, hd_ff} + (ADDR_W+1)'(cnt_ff);
   assign tail    = (tsum >= (ADDR_W+1)'(QUEUE_DEPTH)) ?
                    ADDR_W'(tsum - (ADDR_W+1)'(QUEUE_DEPTH)) : ADDR_W'(tsum);
   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign last    = (CNT_W'(idx_ff) == cnt_dec);
   assign pa_next = next_addr(pa_ff);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      hd_in         = hd_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pa_in         = pa_ff;
      wa_in         = wa_ff;
      key_in        = key_ff;
      op_in         = op_ff;
      res_in        = res_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = wa_ff;
      ram_req.wdata = rdata;
      ram_req.raddr = pa_ff;
      done.valid    = 1'b0;
      done.rsp      = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in              = req_data.item_value;
               op_in               = req_data.opcode;
               res_in.result_value = '0;
               res_in.status       = STATUS_OK;
               res_in.entry_count  = COUNT_W'(cnt_ff);
               unique case (req_data.opcode)
                  OP_PUSH: begin
                     if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        ram_req.we         = 1'b1;
                        ram_req.waddr      = tail;
                        ram_req.wdata      = req_data.item_value;
                        cnt_in             = cnt_ff + CNT_W'(1);
                        res_in.entry_count = COUNT_W'(cnt_ff + CNT_W'(1));
                     end
                     state_in = S_RESP;
                  end
                  OP_POP: begin
                     if (cnt_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        ram_req.raddr = hd_ff;
                        state_in      = S_POPRD;
                     end
                  end
                  OP_FIND, OP_REMOVE: begin
                     if (cnt_ff == '0) begin
                        res_in.status = STATUS_NOT_FOUND;
                        state_in      = S_RESP;
                     end else begin
                        ram_req.raddr = hd_ff;
                        pa_in         = hd_ff;
                        idx_in        = '0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_POPRD: begin
            res_in.result_value = rdata;
            res_in.entry_count  = COUNT_W'(cnt_dec);
            cnt_in              = cnt_dec;
            hd_in               = next_addr(hd_ff);
            state_in            = S_RESP;
         end

         S_SCAN: begin
            // rdata holds the entry at logical index idx_ff
            if (rdata == key_ff) begin
               if (op_ff == OP_FIND) begin
                  state_in = S_RESP;
               end else if (last) begin
                  cnt_in             = cnt_dec;
                  res_in.entry_count = COUNT_W'(cnt_dec);
                  state_in           = S_RESP;
               end else begin
                  // close the gap: each later entry moves up one place
                  wa_in         = pa_ff;
                  pa_in         = pa_next;
                  ram_req.raddr = pa_next;
                  idx_in        = idx_ff + ADDR_W'(1);
                  state_in      = S_SHIFT;
               end
            end else if (last) begin
               res_in.status = STATUS_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               pa_in         = pa_next;
               ram_req.raddr = pa_next;
               idx_in        = idx_ff + ADDR_W'(1);
            end
         end

         S_SHIFT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = wa_ff;
            ram_req.wdata = rdata;
            if (last) begin
               cnt_in             = cnt_dec;
               res_in.entry_count = COUNT_W'(cnt_dec);
               state_in           = S_RESP;
            end else begin
               wa_in         = pa_ff;
               pa_in         = pa_next;
               ram_req.raddr = pa_next;
               idx_in        = idx_ff + ADDR_W'(1);
            end
         end

         S_RESP: begin
            // hold until the output register can take the transfer
            done.valid = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hd_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hd_ff    <= hd_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pa_ff  <= pa_in;
      wa_ff  <= wa_in;
      key_ff <= key_in;
      op_ff  <= op_in;
      res_ff <= res_in;
   end

endmodule

>>> sv/searchable_fifo_queue.sv
// Searchable FIFO queue of 32-bit signed values held in a circular buffer in one
// synchronous RAM. Push writes the tail entry and then responds; pop reads the head entry
// and then responds, or goes straight to the response state on an empty queue. Find and
// remove read one entry per cycle through the single RAM read port. A find stops at its
// first match. A remove then rewrites every later entry one place nearer the head. One
// operation is in flight at a time; its result sits in an output register so the next
// request is taken while it waits.
// Depends on fsq_pkg, fsq_ctrl and fsq_ram.
module searchable_fifo_queue
   import fsq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ram_req_type              ram_req;
   logic signed [DATA_W-1:0] rdata;
   done_type                 done;
   logic                     out_free;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   fsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .rdata     (rdata),
      .ram_req   (ram_req),
      .done      (done)
   );

   fsq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_needs_slot: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> out_free)
      else $error("result produced while output register still occupied");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL) |->
         rsp_data.entry_count == COUNT_W'(QUEUE_DEPTH))
      else $error("full status with a count other than the depth");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_EMPTY) |->
         (rsp_data.entry_count == '0 && rsp_data.result_value == '0))
      else $error("empty status with nonzero count or value");

endmodule
